FILE: design/mbb_pkg.sv
// Shared types, widths and constants for the Mandelbrot bitmap byte unit.
// Used by every module of the block; depends on nothing else.
package mbb_pkg;

    // Fixed point: sign, INT_BITS integer bits, FRAC_BITS fractional bits.
    localparam int FRAC_BITS = 28;
    localparam int INT_BITS  = 7;
    localparam int Q_W       = INT_BITS + FRAC_BITS + 1;
    // Multiplier operands never exceed 16.0 in magnitude while a pixel runs.
    localparam int MAG_W     = FRAC_BITS + 4;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int QUOT_W    = FRAC_BITS + 1;

    localparam int SIZE_W    = 15;
    localparam int ROW_W     = 14;
    localparam int BCOL_W    = 11;
    localparam int ITER_W    = 10;
    localparam int LANES     = 8;
    localparam int LANE_W    = 3;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [SIZE_W-1:0] MAX_SIZE   = 15'd16384;
    localparam logic [SIZE_W-1:0] RESET_SIZE = 15'd16000;
    localparam logic [ITER_W-1:0] RESET_ITER = 10'd50;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 1'b1;

    typedef logic signed [Q_W-1:0] t_q;
    typedef logic signed [Q_W:0]   t_qsum;

    localparam t_q    CI_OFF = t_q'(64'sd1 << FRAC_BITS);
    localparam t_q    CR_OFF = t_q'(64'sd3 << (FRAC_BITS - 1));
    localparam t_qsum FOUR   = t_qsum'(64'sd4 << FRAC_BITS);

    // Last step count of the coordinate division.
    localparam logic [ITER_W-1:0] DIV_LAST = ITER_W'(FRAC_BITS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_INIT,
        ST_ITER_A,
        ST_ITER_B,
        ST_ITER_C,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_div_cmd;

    typedef struct packed {
        logic init;
        logic phase_a;
        logic phase_b;
        logic phase_c;
        logic cont;
    } t_lane_cmd;

    typedef struct packed {
        logic busy;
        logic run;
        logic bounded;
    } t_lane_stat;

endpackage

FILE: design/mbb_div.sv
// Restoring divider giving floor(num * 2^FRAC_BITS / den) for num < 2 * den.
// One quotient bit per step; depends on mbb_pkg.
module mbb_div (
    input  logic                              i_clk,
    input  mbb_pkg::t_div_cmd                 i_cmd,
    input  logic [mbb_pkg::SIZE_W-1:0]        i_num,
    input  logic [mbb_pkg::SIZE_W-1:0]        i_den,
    output logic [mbb_pkg::QUOT_W-1:0]        o_quot
);

    logic [mbb_pkg::SIZE_W-1:0] r_rem;
    logic [mbb_pkg::SIZE_W-1:0] n_rem;
    logic [mbb_pkg::QUOT_W-1:0] r_quot;
    logic [mbb_pkg::QUOT_W-1:0] n_quot;
    logic [mbb_pkg::SIZE_W:0]   rem2;
    logic                       ge_load;
    logic                       ge_step;

    always_comb begin
        rem2    = {r_rem, 1'b0};
        ge_step = rem2 >= {1'b0, i_den};
        ge_load = i_num >= i_den;
        n_rem   = r_rem;
        n_quot  = r_quot;
        if (i_cmd.load) begin
            // The integer part is at most one since num < 2 * den.
            n_rem  = ge_load ? (i_num - i_den) : i_num;
            n_quot = mbb_pkg::QUOT_W'(ge_load);
        end else if (i_cmd.step) begin
            n_rem  = ge_step ? mbb_pkg::SIZE_W'(rem2 - {1'b0, i_den})
                             : rem2[mbb_pkg::SIZE_W-1:0];
            n_quot = {r_quot[mbb_pkg::QUOT_W-2:0], ge_step};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quot <= n_quot;
    end

    assign o_quot = r_quot;

endmodule

FILE: design/mbb_lane.sv
// One pixel lane: forms its c value and runs the z = z^2 + c iteration
// in phases A, B and C. Depends on mbb_pkg.
module mbb_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mbb_pkg::t_lane_cmd            i_cmd,
    input  logic [mbb_pkg::QUOT_W-1:0]    i_quot_r,
    input  logic [mbb_pkg::QUOT_W-1:0]    i_quot_i,
    output mbb_pkg::t_lane_stat           o_stat
);

    mbb_pkg::t_q                  r_cr, n_cr;
    mbb_pkg::t_q                  r_ci, n_ci;
    mbb_pkg::t_q                  r_zr, n_zr;
    mbb_pkg::t_q                  r_zi, n_zi;
    mbb_pkg::t_q                  r_tr, n_tr;
    mbb_pkg::t_q                  r_ti, n_ti;
    logic [mbb_pkg::PROD_W-1:0]   r_prod, n_prod;
    logic                         r_prod_neg, n_prod_neg;
    logic                         r_done, n_done;
    logic                         r_bounded, n_bounded;

    mbb_pkg::t_qsum               mag_sum;
    logic                         le4;
    logic                         run;
    mbb_pkg::t_q                  zr_abs;
    mbb_pkg::t_q                  zi_abs;
    mbb_pkg::t_q                  prod_sh;
    logic [mbb_pkg::PROD_W-1:0]   prod_x;
    logic [mbb_pkg::PROD_W-1:0]   zr_sq;
    logic [mbb_pkg::PROD_W-1:0]   zi_sq;

    always_comb begin
        mag_sum = mbb_pkg::t_qsum'(r_tr) + mbb_pkg::t_qsum'(r_ti);
        le4     = mag_sum <= mbb_pkg::FOUR;
        run     = !r_done && i_cmd.cont && le4;
        zr_abs  = r_zr[mbb_pkg::Q_W-1] ? -r_zr : r_zr;
        zi_abs  = r_zi[mbb_pkg::Q_W-1] ? -r_zi : r_zi;
        // The escape test keeps |z| small, so the magnitudes fit MAG_W bits.
        prod_x  = zi_abs[mbb_pkg::MAG_W-1:0] * zr_abs[mbb_pkg::MAG_W-1:0];
        zr_sq   = zr_abs[mbb_pkg::MAG_W-1:0] * zr_abs[mbb_pkg::MAG_W-1:0];
        zi_sq   = zi_abs[mbb_pkg::MAG_W-1:0] * zi_abs[mbb_pkg::MAG_W-1:0];
        prod_sh = r_prod[mbb_pkg::FRAC_BITS-1 +: mbb_pkg::Q_W];
    end

    always_comb begin
        n_cr       = r_cr;
        n_ci       = r_ci;
        n_zr       = r_zr;
        n_zi       = r_zi;
        n_tr       = r_tr;
        n_ti       = r_ti;
        n_prod     = r_prod;
        n_prod_neg = r_prod_neg;
        n_done     = r_done;
        n_bounded  = r_bounded;
        if (i_cmd.init) begin
            n_cr   = mbb_pkg::t_q'(i_quot_r) - mbb_pkg::CR_OFF;
            n_ci   = mbb_pkg::t_q'(i_quot_i) - mbb_pkg::CI_OFF;
            n_zr   = '0;
            n_zi   = '0;
            n_tr   = '0;
            n_ti   = '0;
            n_done = 1'b0;
        end else if (i_cmd.phase_a && !r_done) begin
            if (run) begin
                n_prod     = prod_x;
                n_prod_neg = r_zi[mbb_pkg::Q_W-1] ^ r_zr[mbb_pkg::Q_W-1];
                n_zr       = r_tr - r_ti + r_cr;
            end else begin
                n_done    = 1'b1;
                n_bounded = le4;
            end
        end else if (i_cmd.phase_b && !r_done) begin
            // 2*Zi*Zr: the magnitude is truncated before the sign goes back on.
            n_zi = (r_prod_neg ? -prod_sh : prod_sh) + r_ci;
            n_tr = zr_sq[mbb_pkg::FRAC_BITS +: mbb_pkg::Q_W];
        end else if (i_cmd.phase_c && !r_done) begin
            n_ti = zi_sq[mbb_pkg::FRAC_BITS +: mbb_pkg::Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b1;
        end else begin
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cr       <= n_cr;
        r_ci       <= n_ci;
        r_zr       <= n_zr;
        r_zi       <= n_zi;
        r_tr       <= n_tr;
        r_ti       <= n_ti;
        r_prod     <= n_prod;
        r_prod_neg <= n_prod_neg;
        r_bounded  <= n_bounded;
    end

    always_comb begin
        o_stat.busy    = !r_done;
        o_stat.run     = run;
        o_stat.bounded = r_bounded;
    end

endmodule

FILE: design/mbb_merge.sv
// Merges the lane results into the pixel byte, the loop-continue flag and the busy flag.
// Depends on mbb_pkg.
module mbb_merge (
    input  mbb_pkg::t_lane_stat [mbb_pkg::LANES-1:0] i_stat,
    input  logic                                     i_oor,
    output logic                                     o_any_run,
    output logic                                     o_any_busy,
    output logic [mbb_pkg::BYTE_W-1:0]               o_byte
);

    always_comb begin
        o_any_run  = 1'b0;
        o_any_busy = 1'b0;
        o_byte     = '0;
        for (int k = 0; k < mbb_pkg::LANES; k++) begin
            o_any_run  = o_any_run | i_stat[k].run;
            o_any_busy = o_any_busy | i_stat[k].busy;
            // Leftmost pixel goes to the top bit.
            o_byte[mbb_pkg::LANES-1-k] = i_stat[k].bounded & !i_oor;
        end
    end

endmodule

FILE: design/mandelbrot_bitmap_byte_unit.sv
// Top level of the Mandelbrot bitmap byte unit: control, configuration,
// dividers, eight pixel lanes and the output register. Depends on mbb_pkg,
// mbb_div, mbb_lane and mbb_merge.
//
//   channel  direction  handshake                   payload
//   in       input      i_in_valid / o_in_stall     i_row, i_byte_col
//   out      output     o_out_valid / i_out_stall   o_row_out, o_byte_col_out,
//                                                   o_pixel_byte, o_out_of_range
//   cfg      input      i_cfg_we                    i_cfg_idx, i_cfg_data
//
// An in-range item passes through a load step, 28 divider steps, a set-up step, phases
// A, B and C of each iteration (at most iteration_limit iterations for its slowest pixel),
// a final escape test and packing. An out-of-range item goes straight to packing, and
// the next transaction is taken in the idle state once the previous result is registered.
// Reset (synchronous, active low) restores 16000 and 50; a stalled result is held while
// the next item is worked on.
module mandelbrot_bitmap_byte_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [mbb_pkg::ROW_W-1:0]         i_row,
    input  logic [mbb_pkg::BCOL_W-1:0]        i_byte_col,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [mbb_pkg::ROW_W-1:0]         o_row_out,
    output logic [mbb_pkg::BCOL_W-1:0]        o_byte_col_out,
    output logic [mbb_pkg::BYTE_W-1:0]        o_pixel_byte,
    output logic                              o_out_of_range,
    input  logic                              i_cfg_we,
    input  logic [mbb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mbb_pkg::SIZE_W-1:0]        i_cfg_data
);

    mbb_pkg::t_state                   r_state, n_state;
    logic [mbb_pkg::ITER_W-1:0]        r_cnt, n_cnt;
    logic [mbb_pkg::SIZE_W-1:0]        r_image_size;
    logic [mbb_pkg::ITER_W-1:0]        r_iter_limit;
    logic [mbb_pkg::ROW_W-1:0]         r_row;
    logic [mbb_pkg::BCOL_W-1:0]        r_bc;
    logic [mbb_pkg::SIZE_W-1:0]        r_size;
    logic                              r_oor;
    logic                              r_out_valid;
    logic [mbb_pkg::ROW_W-1:0]         r_out_row;
    logic [mbb_pkg::BCOL_W-1:0]        r_out_bc;
    logic [mbb_pkg::BYTE_W-1:0]        r_out_byte;
    logic                              r_out_oor;

    logic [mbb_pkg::SIZE_W-1:0]        sz_clamp;
    logic [mbb_pkg::SIZE_W-1:0]        sz_eff;
    logic                              oor_in;
    logic                              in_acc;
    logic                              load_out;
    mbb_pkg::t_div_cmd                 div_cmd;
    mbb_pkg::t_lane_cmd                lane_cmd;
    mbb_pkg::t_lane_stat [mbb_pkg::LANES-1:0] lane_stat;
    logic [mbb_pkg::QUOT_W-1:0]        quot_i;
    logic [mbb_pkg::QUOT_W-1:0]        quot_r [mbb_pkg::LANES];
    logic                              any_run;
    logic                              any_busy;
    logic [mbb_pkg::BYTE_W-1:0]        merged_byte;

    // Effective side: clamped to the largest size, low three bits dropped.
    always_comb begin
        sz_clamp = (r_image_size > mbb_pkg::MAX_SIZE) ? mbb_pkg::MAX_SIZE : r_image_size;
        sz_eff   = {sz_clamp[mbb_pkg::SIZE_W-1:3], 3'b000};
        oor_in   = ({1'b0, i_row} >= sz_eff)
                || ({1'b0, i_byte_col} >= sz_eff[mbb_pkg::SIZE_W-1:3]);
        in_acc   = i_in_valid && !o_in_stall;
        load_out = (r_state == mbb_pkg::ST_FIN) && (!r_out_valid || !i_out_stall);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mbb_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = oor_in ? mbb_pkg::ST_FIN : mbb_pkg::ST_LOAD;
                end
            end
            mbb_pkg::ST_LOAD: n_state = mbb_pkg::ST_DIV;
            mbb_pkg::ST_DIV: begin
                if (r_cnt == mbb_pkg::DIV_LAST) begin
                    n_state = mbb_pkg::ST_INIT;
                end
            end
            mbb_pkg::ST_INIT:   n_state = mbb_pkg::ST_ITER_A;
            mbb_pkg::ST_ITER_A: n_state = any_run ? mbb_pkg::ST_ITER_B : mbb_pkg::ST_FIN;
            mbb_pkg::ST_ITER_B: n_state = mbb_pkg::ST_ITER_C;
            mbb_pkg::ST_ITER_C: n_state = mbb_pkg::ST_ITER_A;
            mbb_pkg::ST_FIN: begin
                if (load_out) begin
                    n_state = mbb_pkg::ST_IDLE;
                end
            end
            default: n_state = mbb_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_stall       = 1'b1;
        div_cmd.load     = 1'b0;
        div_cmd.step     = 1'b0;
        lane_cmd.init    = 1'b0;
        lane_cmd.phase_a = 1'b0;
        lane_cmd.phase_b = 1'b0;
        lane_cmd.phase_c = 1'b0;
        lane_cmd.cont    = r_cnt < r_iter_limit;
        n_cnt            = r_cnt;
        case (r_state)
            mbb_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                n_cnt      = '0;
            end
            mbb_pkg::ST_LOAD: div_cmd.load = 1'b1;
            mbb_pkg::ST_DIV: begin
                div_cmd.step = 1'b1;
                n_cnt        = r_cnt + 1'b1;
            end
            mbb_pkg::ST_INIT: begin
                lane_cmd.init = 1'b1;
                n_cnt         = '0;
            end
            mbb_pkg::ST_ITER_A: lane_cmd.phase_a = 1'b1;
            mbb_pkg::ST_ITER_B: lane_cmd.phase_b = 1'b1;
            mbb_pkg::ST_ITER_C: begin
                lane_cmd.phase_c = 1'b1;
                n_cnt            = r_cnt + 1'b1;
            end
            mbb_pkg::ST_FIN: n_cnt = r_cnt;
            default: n_cnt = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mbb_pkg::ST_IDLE;
            r_cnt        <= '0;
            r_image_size <= mbb_pkg::RESET_SIZE;
            r_iter_limit <= mbb_pkg::RESET_ITER;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mbb_pkg::CFG_IMAGE_SIZE: r_image_size <= i_cfg_data;
                    mbb_pkg::CFG_ITER_LIMIT: r_iter_limit <= i_cfg_data[mbb_pkg::ITER_W-1:0];
                    default: r_iter_limit <= r_iter_limit;
                endcase
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_row  <= i_row;
            r_bc   <= i_byte_col;
            r_size <= sz_eff;
            r_oor  <= oor_in;
        end
        if (load_out) begin
            r_out_row  <= r_row;
            r_out_bc   <= r_bc;
            r_out_byte <= merged_byte;
            r_out_oor  <= r_oor;
        end
    end

    // Imaginary part, shared by all lanes: floor(2 * row * 2^F / size).
    mbb_div u_div_ci (
        .i_clk  (i_clk),
        .i_cmd  (div_cmd),
        .i_num  ({r_row, 1'b0}),
        .i_den  (r_size),
        .o_quot (quot_i)
    );

    for (genvar k = 0; k < mbb_pkg::LANES; k++) begin : g_lane
        mbb_div u_div_cr (
            .i_clk  (i_clk),
            .i_cmd  (div_cmd),
            .i_num  ({r_bc, mbb_pkg::LANE_W'(k), 1'b0}),
            .i_den  (r_size),
            .o_quot (quot_r[k])
        );

        mbb_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (lane_cmd),
            .i_quot_r (quot_r[k]),
            .i_quot_i (quot_i),
            .o_stat   (lane_stat[k])
        );
    end

    mbb_merge u_merge (
        .i_stat     (lane_stat),
        .i_oor      (r_oor),
        .o_any_run  (any_run),
        .o_any_busy (any_busy),
        .o_byte     (merged_byte)
    );

    assign o_out_valid    = r_out_valid;
    assign o_row_out      = r_out_row;
    assign o_byte_col_out = r_out_bc;
    assign o_pixel_byte   = r_out_byte;
    assign o_out_of_range = r_out_oor;

    // An out-of-range result never carries pixel bits.
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_of_range |-> o_pixel_byte == '0)
        else $error("out-of-range result with pixel bits set");

    // The middle of an iteration only happens while some lane still runs.
    a_busy_in_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mbb_pkg::ST_ITER_B |-> any_busy)
        else $error("iteration phase with every lane finished");

    // No lane goes past the iteration limit.
    a_iter_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mbb_pkg::ST_ITER_B |-> r_cnt < r_iter_limit)
        else $error("iteration beyond the limit");

    // Lane set-up follows a complete division.
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mbb_pkg::ST_DIV && r_cnt == mbb_pkg::DIV_LAST
        |=> r_state == mbb_pkg::ST_INIT)
        else $error("division not followed by lane set-up");

endmodule
